// ===== rtl/crrd_pkg.sv =====
// Shared types and constants for the credit-limited round-robin dispatcher.
// Used by crrd_outq, crrd_check, the top level and the testbench; no dependencies of its own.
package crrd_pkg;

    localparam int CHANNEL_COUNT_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF    = 8;
    localparam int INFLIGHT_DEPTH_DEF = 16;

    localparam int TOTAL_CREDIT_EXTRA = 4;
    localparam int TYPE_CREDIT_EXTRA  = 2;
    localparam int QUEUE_CREDIT       = 2;
    localparam int ACTIVE_RESET       = 4;

    localparam logic [1:0] EV_SENT   = 2'd0;
    localparam logic [1:0] EV_DONE   = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;

    localparam logic [3:0] DEVICE_QID = 4'd8;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] tag;
        logic [3:0] qid;
    } t_result;

    typedef struct packed {
        logic [7:0] tag;
        logic [3:0] qid;
        logic       typ;
    } t_flight;

    typedef struct packed {
        logic    push;
        logic    flush;
        t_result res;
    } t_emit_ctl;

endpackage

// ===== rtl/crrd_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module crrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/crrd_outq.sv =====
// Result holding stage and output register. One result is held back so that
// the final result of an input item can be marked last. Uses crrd_pkg.
module crrd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crrd_pkg::t_emit_ctl i_ctl,
    output logic               o_room,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output crrd_pkg::t_result  o_res,
    output logic               o_last
);
    import crrd_pkg::*;

    logic    r_pv;
    logic    r_ov;
    logic    r_olast;
    t_result r_pend;
    t_result r_out;

    assign o_room = !r_pv || !r_ov || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ctl.push) begin
            if (r_pv) begin
                r_ov    <= 1'b1;
                r_out   <= r_pend;
                r_olast <= 1'b0;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            r_pend <= i_ctl.res;
            r_pv   <= 1'b1;
        end else if (i_ctl.flush && r_pv) begin
            r_ov    <= 1'b1;
            r_out   <= r_pend;
            r_olast <= 1'b1;
            r_pv    <= 1'b0;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_res      = r_out;
    assign o_last     = r_olast;
endmodule

// ===== rtl/credit_limited_round_robin_dispatch.sv =====
// Credit-limited round-robin dispatcher, top level: sequencer and state memories.
// Uses crrd_pkg, crrd_ram and crrd_outq.
//
// One input transaction is taken at a time. The sequencer takes and files a request
// or reads a response, checks the device queue and sends from it while credit allows,
// scans the channel queues in turn, sending from each one visited that has an entry
// and credit, and then ends the scan and closes the item. The pace is set by the
// single sequencer walking the queues, with one read port on each queue memory and
// on the in-flight memory. Results wait in a holding register, so the output side
// may stall; the sequencer then waits. The queue memories need no clearing after
// reset.
module credit_limited_round_robin_dispatch #(
    parameter int CHANNEL_COUNT  = crrd_pkg::CHANNEL_COUNT_DEF,
    parameter int QUEUE_DEPTH    = crrd_pkg::QUEUE_DEPTH_DEF,
    parameter int INFLIGHT_DEPTH = crrd_pkg::INFLIGHT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,  // active_channels
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // channel[1:0], tag[9:2], zero[15:10]
    input  logic [2:0]  i_s_tuser,    // op[0], device_wide[1], is_channel_packet[2]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // out_tag[7:0], queue_id[11:8], zero[15:12]
    output logic [1:0]  o_m_tuser,    // event_res[1:0]
    output logic        o_m_tlast
);
    import crrd_pkg::*;

    localparam int NQ  = 2 * CHANNEL_COUNT;
    localparam int QW  = $clog2(NQ);
    localparam int QXW = (QW > 4) ? QW : 4;
    localparam int RW  = QW + 1;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = $clog2(NQ * QUEUE_DEPTH);
    localparam int FPW = $clog2(INFLIGHT_DEPTH);
    localparam int FCW = $clog2(INFLIGHT_DEPTH + 1);
    localparam int WCW = $clog2(NQ * QUEUE_DEPTH + QUEUE_DEPTH + 1);
    localparam int ACT_RST = (CHANNEL_COUNT < ACTIVE_RESET) ? CHANNEL_COUNT : ACTIVE_RESET;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FILE     = 4'd1;
    localparam logic [3:0] S_RESP_RD  = 4'd2;
    localparam logic [3:0] S_RESP     = 4'd3;
    localparam logic [3:0] S_DEV      = 4'd4;
    localparam logic [3:0] S_DEV_SEND = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_SEND     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]     r_state, n_state;
    logic [2:0]     r_ac;
    logic           r_dev, r_cp;
    logic [1:0]     r_ch;
    logic [7:0]     r_tag;
    logic [CW-1:0]  r_cnt  [NQ];
    logic [PW-1:0]  r_head [NQ];
    logic [1:0]     r_pq   [NQ];
    logic [3:0]     r_pt0, r_pt1;
    logic [QW-1:0]  r_rr;
    logic [RW-1:0]  r_j;
    logic [CW-1:0]  r_dcount;
    logic [PW-1:0]  r_dhead;
    logic [FCW-1:0] r_fcount;
    logic [FPW-1:0] r_fhead;
    logic [WCW-1:0] r_wait;

    logic [QXW-1:0] q_in_ext, fl_qid_ext;
    logic           q_in_ok, fl_q_ok;
    logic [QW-1:0]  q_sel;
    logic [CW-1:0]  cnt_sel;
    logic [PW-1:0]  head_sel;
    logic [1:0]     pq_sel;
    logic           total_ok, type0_ok, scan_type_ok, dev_can, scan_can;
    logic [RW-1:0]  queues;
    logic [QW-1:0]  rr_next;
    logic [CW:0]    cq_sum, dq_sum;
    logic [PW-1:0]  cq_tail, dq_tail;
    logic [FCW:0]   fl_sum;
    logic [FPW-1:0] fl_tail;
    logic           room, file_reject;
    t_flight        fl_rd;
    logic [12:0]    fl_rdata;
    logic [7:0]     cq_rdata, dq_rdata;
    logic           cq_we, cq_re, dq_we, dq_re, fl_we, fl_re;
    logic [AW-1:0]  cq_waddr, cq_raddr;
    t_flight        fl_wdata;
    t_emit_ctl      emit;
    t_result        out_res;

    assign fl_rd      = t_flight'(fl_rdata);
    assign q_in_ext   = QXW'({r_ch, r_cp});
    assign q_in_ok    = ({1'b0, r_ch} < r_ac) && (q_in_ext < QXW'(NQ));
    assign fl_qid_ext = QXW'(fl_rd.qid);
    assign fl_q_ok    = (fl_rd.qid != DEVICE_QID) && (fl_qid_ext < QXW'(NQ));

    always_comb begin
        unique case (r_state)
            S_FILE:  q_sel = q_in_ext[QW-1:0];
            S_RESP:  q_sel = fl_qid_ext[QW-1:0];
            default: q_sel = r_rr;
        endcase
    end

    assign cnt_sel  = r_cnt[q_sel];
    assign head_sel = r_head[q_sel];
    assign pq_sel   = r_pq[q_sel];

    assign total_ok = (8'(r_fcount) < 8'(INFLIGHT_DEPTH)) &&
                      (8'(r_fcount) < 8'({r_ac, 1'b0}) + 8'(TOTAL_CREDIT_EXTRA));
    assign type0_ok = r_pt0 < 4'(r_ac) + 4'(TYPE_CREDIT_EXTRA);
    assign scan_type_ok = (r_rr[0] ? r_pt1 : r_pt0) < 4'(r_ac) + 4'(TYPE_CREDIT_EXTRA);
    assign dev_can  = (r_dcount != '0) && total_ok && type0_ok;
    assign scan_can = (cnt_sel != '0) && total_ok && scan_type_ok &&
                      (pq_sel < 2'(QUEUE_CREDIT));

    assign queues  = RW'({r_ac, 1'b0});
    assign rr_next = (RW'(r_rr) + RW'(1) == queues) ? '0 : r_rr + QW'(1);

    // Ring positions of the queue tails.
    assign cq_sum  = (CW+1)'(head_sel) + (CW+1)'(cnt_sel);
    assign cq_tail = (cq_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     PW'(cq_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(cq_sum);
    assign dq_sum  = (CW+1)'(r_dhead) + (CW+1)'(r_dcount);
    assign dq_tail = (dq_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     PW'(dq_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(dq_sum);
    assign fl_sum  = (FCW+1)'(r_fhead) + (FCW+1)'(r_fcount);
    assign fl_tail = (fl_sum >= (FCW+1)'(INFLIGHT_DEPTH)) ?
                     FPW'(fl_sum - (FCW+1)'(INFLIGHT_DEPTH)) : FPW'(fl_sum);

    assign cq_waddr = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(cq_tail);
    assign cq_raddr = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(head_sel);

    assign file_reject = r_dev ? (r_dcount >= CW'(QUEUE_DEPTH))
                               : (!q_in_ok || cnt_sel >= CW'(QUEUE_DEPTH));

    assign cq_we = (r_state == S_FILE) && !r_dev && !file_reject;
    assign dq_we = (r_state == S_FILE) && r_dev && !file_reject;
    assign cq_re = (r_state == S_SCAN) && (r_j < queues) && (r_wait != '0) && scan_can;
    assign dq_re = (r_state == S_DEV) && dev_can;
    assign fl_re = (r_state == S_RESP_RD) && (r_fcount != '0);
    assign fl_we = ((r_state == S_DEV_SEND) || (r_state == S_SEND)) && room;

    always_comb begin
        fl_wdata.tag = cq_rdata;
        fl_wdata.qid = 4'(r_rr);
        fl_wdata.typ = r_rr[0];
        if (r_state == S_DEV_SEND) begin
            fl_wdata.tag = dq_rdata;
            fl_wdata.qid = DEVICE_QID;
            fl_wdata.typ = 1'b0;
        end
    end

    always_comb begin
        emit.push  = 1'b0;
        emit.flush = 1'b0;
        emit.res   = '{ev: EV_SENT, tag: cq_rdata, qid: 4'(r_rr)};
        unique case (r_state)
            S_FILE: begin
                emit.push = file_reject && room;
                emit.res  = '{ev: EV_REJECT, tag: r_tag,
                              qid: r_dev ? DEVICE_QID : 4'({r_ch, r_cp})};
            end
            S_RESP: begin
                emit.push = room;
                emit.res  = '{ev: EV_DONE, tag: fl_rd.tag, qid: fl_rd.qid};
            end
            S_DEV_SEND: begin
                emit.push = room;
                emit.res  = '{ev: EV_SENT, tag: dq_rdata, qid: DEVICE_QID};
            end
            S_SEND:  emit.push = room;
            // The held result may only move on once the output register is free.
            S_FIN:   emit.flush = room;
            default: emit.push = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_s_tvalid) n_state = i_s_tuser[0] ? S_RESP_RD : S_FILE;
            S_FILE:     if (!file_reject || room) n_state = S_DEV;
            S_RESP_RD:  n_state = (r_fcount != '0) ? S_RESP : S_DEV;
            S_RESP:     if (room) n_state = S_DEV;
            S_DEV:      n_state = dev_can ? S_DEV_SEND : S_SCAN;
            S_DEV_SEND: if (room) n_state = S_DEV;
            S_SCAN: begin
                if (!((r_j < queues) && (r_wait != '0))) n_state = S_FIN;
                else if (scan_can) n_state = S_SEND;
            end
            S_SEND:     if (room) n_state = S_SCAN;
            S_FIN:      if (room) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_dev <= i_s_tuser[1];
            r_cp  <= i_s_tuser[2];
            r_ch  <= i_s_tdata[1:0];
            r_tag <= i_s_tdata[9:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ac     <= 3'(ACT_RST);
            r_pt0    <= '0;
            r_pt1    <= '0;
            r_rr     <= '0;
            r_j      <= '0;
            r_dcount <= '0;
            r_dhead  <= '0;
            r_fcount <= '0;
            r_fhead  <= '0;
            r_wait   <= '0;
            for (int i = 0; i < NQ; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
                r_pq[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_wdata == 3'd0) r_ac <= 3'd1;
                else if (int'(i_cfg_wdata) > CHANNEL_COUNT) r_ac <= 3'(CHANNEL_COUNT);
                else r_ac <= i_cfg_wdata;
            end
            unique case (r_state)
                S_FILE: begin
                    if (!file_reject) begin
                        r_wait <= r_wait + WCW'(1);
                        if (r_dev) r_dcount <= r_dcount + CW'(1);
                        else r_cnt[q_sel] <= cnt_sel + CW'(1);
                    end
                end
                S_RESP: begin
                    if (room) begin
                        if (fl_q_ok) begin
                            if (fl_rd.typ) begin
                                if (r_pt1 != '0) r_pt1 <= r_pt1 - 4'd1;
                            end else begin
                                if (r_pt0 != '0) r_pt0 <= r_pt0 - 4'd1;
                            end
                            if (pq_sel != '0) r_pq[q_sel] <= pq_sel - 2'd1;
                        end
                        r_fhead  <= (r_fhead == FPW'(INFLIGHT_DEPTH - 1)) ? '0
                                                                           : r_fhead + FPW'(1);
                        r_fcount <= r_fcount - FCW'(1);
                    end
                end
                S_DEV: begin
                    if (!dev_can) begin
                        // A shrunk channel count can leave the pointer out of range.
                        if (RW'(r_rr) >= queues) r_rr <= '0;
                        r_j <= '0;
                    end
                end
                S_DEV_SEND: begin
                    if (room) begin
                        r_fcount <= r_fcount + FCW'(1);
                        r_dhead  <= (r_dhead == PW'(QUEUE_DEPTH - 1)) ? '0 : r_dhead + PW'(1);
                        r_dcount <= r_dcount - CW'(1);
                        r_wait   <= r_wait - WCW'(1);
                    end
                end
                S_SCAN: begin
                    if ((r_j < queues) && (r_wait != '0) && !scan_can) begin
                        r_j  <= r_j + RW'(1);
                        r_rr <= rr_next;
                    end
                end
                S_SEND: begin
                    if (room) begin
                        if (r_rr[0]) r_pt1 <= r_pt1 + 4'd1;
                        else r_pt0 <= r_pt0 + 4'd1;
                        r_pq[q_sel]   <= pq_sel + 2'd1;
                        r_fcount      <= r_fcount + FCW'(1);
                        r_head[q_sel] <= (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : head_sel + PW'(1);
                        r_cnt[q_sel]  <= cnt_sel - CW'(1);
                        r_wait        <= r_wait - WCW'(1);
                        // A send restarts the visit count for a full lap.
                        r_j  <= RW'(1);
                        r_rr <= rr_next;
                    end
                end
                default: r_j <= r_j;
            endcase
        end
    end

    crrd_ram #(.WIDTH(8), .DEPTH(NQ * QUEUE_DEPTH)) u_chq (
        .i_clk   (i_clk),
        .i_we    (cq_we),
        .i_waddr (cq_waddr),
        .i_wdata (r_tag),
        .i_re    (cq_re),
        .i_raddr (cq_raddr),
        .o_rdata (cq_rdata)
    );

    crrd_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_devq (
        .i_clk   (i_clk),
        .i_we    (dq_we),
        .i_waddr (dq_tail),
        .i_wdata (r_tag),
        .i_re    (dq_re),
        .i_raddr (r_dhead),
        .o_rdata (dq_rdata)
    );

    crrd_ram #(.WIDTH(13), .DEPTH(INFLIGHT_DEPTH)) u_flight (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_tail),
        .i_wdata (fl_wdata),
        .i_re    (fl_re),
        .i_raddr (r_fhead),
        .o_rdata (fl_rdata)
    );

    crrd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (emit),
        .o_room     (room),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (out_res),
        .o_last     (o_m_tlast)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tdata  = {4'b0, out_res.qid, out_res.tag};
    assign o_m_tuser  = out_res.ev;
endmodule

// ===== rtl/crrd_check.sv =====
// Port-level checks for the dispatcher, bound to its top level.
// Uses crrd_pkg.
module crrd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import crrd_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result transaction dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second input taken while an item is in work");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == EV_SENT || o_m_tuser == EV_DONE ||
                        o_m_tuser == EV_REJECT))
        else $error("undefined result event");
endmodule

bind credit_limited_round_robin_dispatch crrd_check u_crrd_check (.*);

// ===== tb/credit_limited_round_robin_dispatch_tb.sv =====
// Self-checking testbench for the credit-limited round-robin dispatcher.
// Depends on crrd_pkg and credit_limited_round_robin_dispatch from the rtl folder.
module credit_limited_round_robin_dispatch_tb;
    import crrd_pkg::*;

    localparam int NUM_QUEUES  = 8;
    localparam int QDEPTH      = 8;
    localparam int FLIGHT_MAX  = 16;
    localparam int RESULTS_MAX = 13;
    localparam int SETTLE      = 80;

    typedef struct {
        logic [1:0] ev;
        logic [7:0] tag;
        logic [3:0] qid;
        logic       last;
    } t_outcome;

    class dispatch_scoreboard;
        int         active;
        logic [7:0] chan_q[NUM_QUEUES][$];
        logic [7:0] dev_q[$];
        t_flight    flight[$];
        int         per_type[2];
        int         per_queue[NUM_QUEUES];
        int         rr;
        int         waiting;
        t_outcome   expected[$];
        t_outcome   cur[$];
        int         errors;
        int         mismatches;
        int         n_sent;
        int         n_done;
        int         n_reject;

        function void reset_state();
            active = ACTIVE_RESET;
            rr = 0;
            waiting = 0;
            foreach (per_queue[i]) per_queue[i] = 0;
            per_type[0] = 0;
            per_type[1] = 0;
        endfunction

        function void set_active(logic [2:0] v);
            if (v < 1) active = 1;
            else if (v > 4) active = 4;
            else active = int'(v);
        endfunction

        function bit credit_ok(int typ, int q);
            if (flight.size() >= FLIGHT_MAX) return 0;
            if (flight.size() >= 2 * active + TOTAL_CREDIT_EXTRA) return 0;
            if (per_type[typ] >= active + TYPE_CREDIT_EXTRA) return 0;
            if (q >= 0 && per_queue[q] >= QUEUE_CREDIT) return 0;
            return 1;
        endfunction

        function void add(logic [1:0] ev, logic [7:0] tg, logic [3:0] qid);
            t_outcome o;
            if (cur.size() >= RESULTS_MAX) return;
            o.ev = ev;
            o.tag = tg;
            o.qid = qid;
            o.last = 0;
            cur.push_back(o);
        endfunction

        // Works out every result that one accepted input transaction causes.
        function void note_transaction(bit op, bit dev, logic [1:0] ch, bit cp,
                                       logic [7:0] tg);
            int      nq;
            int      q;
            int      j;
            logic [7:0] t;
            t_flight f;
            cur.delete();
            nq = 2 * active;
            if (op == 0) begin
                if (dev) begin
                    if (dev_q.size() >= QDEPTH) add(EV_REJECT, tg, DEVICE_QID);
                    else begin
                        dev_q.push_back(tg);
                        waiting++;
                    end
                end else begin
                    q = 2 * ch + cp;
                    if (ch >= active || chan_q[q].size() >= QDEPTH) begin
                        add(EV_REJECT, tg, q[3:0]);
                    end else begin
                        chan_q[q].push_back(tg);
                        waiting++;
                    end
                end
            end else if (flight.size() > 0) begin
                f = flight.pop_front();
                if (f.qid != DEVICE_QID) begin
                    if (per_type[f.typ] > 0) per_type[f.typ]--;
                    if (per_queue[f.qid] > 0) per_queue[f.qid]--;
                end
                add(EV_DONE, f.tag, f.qid);
            end
            while (dev_q.size() > 0 && credit_ok(0, -1)) begin
                t = dev_q.pop_front();
                add(EV_SENT, t, DEVICE_QID);
                flight.push_back('{t, DEVICE_QID, 1'b0});
                waiting--;
            end
            if (rr >= nq) rr = 0;
            j = 0;
            // A send restarts the count of visits, so the scan goes round again.
            while (j < nq && waiting > 0) begin
                q = rr;
                if (chan_q[q].size() != 0 && credit_ok(q % 2, q)) begin
                    t = chan_q[q].pop_front();
                    add(EV_SENT, t, q[3:0]);
                    per_type[q % 2]++;
                    per_queue[q]++;
                    flight.push_back('{t, q[3:0], q[0]});
                    waiting--;
                    j = 0;
                end
                j++;
                rr = (rr + 1) % nq;
            end
            if (cur.size() > 0) cur[cur.size() - 1].last = 1;
            foreach (cur[i]) expected.push_back(cur[i]);
        endfunction

        function void check_result(logic [1:0] ev, logic [7:0] tg, logic [3:0] qid,
                                   logic last);
            t_outcome e;
            if (expected.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result ev=%0d tag=%0d qid=%0d last=%0d",
                             ev, tg, qid, last);
                return;
            end
            e = expected.pop_front();
            case (ev)
                EV_SENT:   n_sent++;
                EV_DONE:   n_done++;
                EV_REJECT: n_reject++;
                default:   ;
            endcase
            if (e.ev !== ev || e.tag !== tg || e.qid !== qid || e.last !== last) begin
                errors++;
                if (mismatches++ < 10)
                    $display({"mismatch: expected ev=%0d tag=%0d qid=%0d last=%0d, ",
                              "got ev=%0d tag=%0d qid=%0d last=%0d"},
                             e.ev, e.tag, e.qid, e.last, ev, tg, qid, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    dispatch_scoreboard sb;
    bit idle_en;
    int hold_cycles;
    int accepted;

    credit_limited_round_robin_dispatch DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result side: random back-pressure when idle_en is set, else always ready, or a long counted hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_m_tready <= idle_en ? ($urandom_range(0, 99) >= 22) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata[7:0], o_m_tdata[11:8], o_m_tlast);
    end

    initial begin
        #3_000_000;
        $display("timeout");
        $display("credit_limited_round_robin_dispatch_tb NOT OK");
        $finish;
    end

    task automatic send_item(bit op, bit dev, logic [1:0] ch, bit cp, logic [7:0] tg);
        while (idle_en && $urandom_range(0, 99) < 22) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, tg, ch};
        i_s_tuser  <= {cp, dev, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_transaction(op, dev, ch, cp, tg);
        accepted++;
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++)
            send_item($urandom_range(0, 99) < 35, $urandom_range(0, 99) < 15,
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        i_s_tvalid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the block finish any silent work.
    task automatic drain();
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_active(logic [2:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_active(v);
    endtask

    initial begin
        logic [2:0] settings[8] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
        sb = new();
        sb.reset_state();
        idle_en = 1'b1;
        hold_cycles = 0;
        accepted = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: response with nothing in flight, queue 0 filled until rejected,
        // the device queue, every other queue, then completions.
        send_item(1'b1, 1'b0, 2'd0, 1'b0, 8'h00);
        for (int k = 0; k < 11; k++)
            send_item(1'b0, 1'b0, 2'd0, 1'b0, (k == 0) ? 8'h00 : 8'(8'hFF - k));
        send_item(1'b0, 1'b1, 2'd3, 1'b1, 8'hFF);
        for (int q = 1; q < NUM_QUEUES; q++)
            send_item(1'b0, 1'b0, 2'(q / 2), 1'(q % 2), 8'(8'h10 + q));
        repeat (3) send_item(1'b1, 1'b0, 2'd0, 1'b0, 8'h00);
        i_s_tvalid <= 1'b0;

        // Inactive channel with a single channel in use.
        write_active(3'd1);
        send_item(1'b0, 1'b0, 2'd2, 1'b0, 8'hA5);
        send_item(1'b0, 1'b0, 2'd0, 1'b1, 8'h5A);
        i_s_tvalid <= 1'b0;

        foreach (settings[p]) begin
            write_active(settings[p]);
            idle_en = (p != 2);
            if (p == 4) hold_cycles = 400;
            send_random(30);
        end
        idle_en = 1'b1;
        drain();

        $display("%0d input transactions; %0d sends, %0d completions, %0d rejects checked",
                 accepted, sb.n_sent, sb.n_done, sb.n_reject);
        $display("channel counts 1 to 4 and out-of-range settings, with stalls on both sides");
        if (sb.errors == 0) $display("credit_limited_round_robin_dispatch_tb OK");
        else $display("credit_limited_round_robin_dispatch_tb NOT OK");
        $finish;
    end
endmodule
